[design/esort_pkg.sv]
// Shared types, constants and the control store for the exchange sort engine.
// No dependencies; the engine, sequencer, datapath and bench refer to this package.
package esort_pkg;

  localparam int WORD_W = 32;
  localparam int STEP_W = 3;

  typedef logic [STEP_W-1:0] step_t;

  // control store addresses
  localparam step_t STEP_LOAD = 3'd0;
  localparam step_t STEP_RDI  = 3'd1;
  localparam step_t STEP_LDA  = 3'd2;
  localparam step_t STEP_RDJ  = 3'd3;
  localparam step_t STEP_CMP  = 3'd4;
  localparam step_t STEP_EMIT = 3'd5;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NONE   = 3'd0,
    CND_OPEN   = 3'd1,
    CND_J_DONE = 3'd2,
    CND_J_LAST = 3'd3,
    CND_MORE   = 3'd4
  } cond_t;

  // one control word
  typedef struct packed {
    logic  load;
    logic  rd_i;
    logic  lat_a;
    logic  rd_j;
    logic  cmp;
    logic  emit;
    cond_t cond;
    step_t jmp;
    step_t seq;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic close;
    logic j_done;
    logic j_last;
    logic i_last;
  } status_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '0;
    w.cond = CND_NONE;
    w.jmp  = STEP_LOAD;
    w.seq  = STEP_LOAD;
    case (step)
      STEP_LOAD: begin
        w.load = 1'b1; w.cond = CND_OPEN; w.jmp = STEP_LOAD; w.seq = STEP_RDI;
      end
      STEP_RDI: begin
        w.rd_i = 1'b1; w.seq = STEP_LDA;
      end
      STEP_LDA: begin
        w.lat_a = 1'b1; w.cond = CND_J_DONE; w.jmp = STEP_EMIT; w.seq = STEP_RDJ;
      end
      STEP_RDJ: begin
        w.rd_j = 1'b1; w.seq = STEP_CMP;
      end
      STEP_CMP: begin
        w.cmp = 1'b1; w.cond = CND_J_LAST; w.jmp = STEP_EMIT; w.seq = STEP_RDJ;
      end
      STEP_EMIT: begin
        w.emit = 1'b1; w.cond = CND_MORE; w.jmp = STEP_RDI; w.seq = STEP_LOAD;
      end
      default: begin
        w.seq = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

[design/exchange_sort_engine_unit.sv]
// Exchange sort engine: loads signed words, sorts them ascending, streams the result.
// Channels: start/busy command port with in_value, in_last_in; result beats on
//   out_strobe with out_sorted_value and out_last_out, one cycle each, never stalled.
// Loading: one word per cycle while busy is low. The word with in_last_in set, or
//   the word that fills the MAX_LEN-entry store, closes the set and raises busy.
// Sorting: a control-store sequencer drives each compare as a read step and a compare
//   step through the single read port of the element store. Position i reads element
//   i, compares it against each later element in turn and ends with its result beat,
//   and busy stays high while the set is sorted. The final beat carries out_last_out.
// The store read port (one access per cycle) sets the compare rate.
// Busy drops in the cycle that shows the final beat; the next word may be taken
//   at the edge that ends that cycle.
// Reset (rst_n low at a clock edge) returns to loading with an empty set.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
// Depends on esort_pkg, esort_seq, esort_dp and esort_ram.
module exchange_sort_engine_unit #(
  parameter int MAX_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [esort_pkg::WORD_W-1:0] in_value,
  input  logic                         in_last_in,
  output logic                         out_strobe,
  output logic [esort_pkg::WORD_W-1:0] out_sorted_value,
  output logic                         out_last_out
);

  esort_pkg::ctrl_t   ctrl;
  esort_pkg::status_t sts;

  assign busy = !ctrl.load;

  esort_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctrl  (ctrl)
  );

  esort_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .start            (start),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .sts              (sts),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out)
  );

endmodule

[design/esort_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module esort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/esort_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on esort_pkg.
module esort_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  esort_pkg::status_t sts,
  output esort_pkg::ctrl_t  ctrl
);

  esort_pkg::step_t step_r;
  esort_pkg::step_t step_nxt;
  logic             taken;

  assign ctrl = esort_pkg::ucode(step_r);

  always_comb begin
    case (ctrl.cond)
      esort_pkg::CND_NONE:   taken = 1'b0;
      esort_pkg::CND_OPEN:   taken = !sts.close;
      esort_pkg::CND_J_DONE: taken = sts.j_done;
      esort_pkg::CND_J_LAST: taken = sts.j_last;
      esort_pkg::CND_MORE:   taken = !sts.i_last;
      default:               taken = 1'b0;
    endcase
    step_nxt = taken ? ctrl.jmp : ctrl.seq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= esort_pkg::STEP_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[design/esort_dp.sv]
// Datapath: element store, fill count, sort indices, running minimum, result register.
// Depends on esort_pkg and esort_ram.
module esort_dp #(
  parameter int MAX_LEN = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  esort_pkg::ctrl_t                  ctrl,
  input  logic                              start,
  input  logic [esort_pkg::WORD_W-1:0]      in_value,
  input  logic                              in_last_in,
  output esort_pkg::status_t                sts,
  output logic                              out_strobe,
  output logic [esort_pkg::WORD_W-1:0]      out_sorted_value,
  output logic                              out_last_out
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [esort_pkg::WORD_W-1:0] a_r, a_nxt;
  logic                         strobe_r;
  logic [esort_pkg::WORD_W-1:0] oval_r;
  logic                         olast_r;

  logic                         accept;
  logic [CW-1:0]                fill_inc;
  logic                         full;
  logic                         swap;
  logic                         we;
  logic [IW-1:0]                waddr;
  logic [IW-1:0]                raddr;
  logic [esort_pkg::WORD_W-1:0] wdata;
  logic [esort_pkg::WORD_W-1:0] rdata;

  assign accept   = ctrl.load & start;
  assign fill_inc = fill_r + CW'(1);
  assign full     = (fill_inc == CW'(MAX_LEN));
  assign swap     = ctrl.cmp & ($signed(a_r) > $signed(rdata));

  assign sts.close  = accept & (in_last_in | full);
  assign sts.j_done = (j_r == n_r);
  assign sts.j_last = ((j_r + CW'(1)) == n_r);
  assign sts.i_last = ((i_r + CW'(1)) == n_r);

  assign we    = accept | swap;
  assign waddr = ctrl.load ? fill_r[IW-1:0] : j_r[IW-1:0];
  assign wdata = ctrl.load ? in_value : a_r;
  assign raddr = ctrl.rd_j ? j_r[IW-1:0] : i_r[IW-1:0];

  esort_ram #(
    .WIDTH (esort_pkg::WORD_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    fill_nxt = fill_r;
    n_nxt    = n_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    a_nxt    = a_r;
    if (accept) begin
      // close the set: capture its length and restart the outer index
      if (sts.close) begin
        fill_nxt = '0;
        n_nxt    = fill_inc;
        i_nxt    = '0;
      end else begin
        fill_nxt = fill_inc;
      end
    end
    if (ctrl.rd_i) begin
      j_nxt = i_r + CW'(1);
    end
    if (ctrl.lat_a) begin
      a_nxt = rdata;
    end
    if (ctrl.cmp) begin
      // keep the smaller value; the larger one goes back to the later slot
      if (swap) begin
        a_nxt = rdata;
      end
      j_nxt = j_r + CW'(1);
    end
    if (ctrl.emit) begin
      i_nxt = i_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      i_r      <= '0;
      j_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      strobe_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    a_r <= a_nxt;
    if (ctrl.emit) begin
      oval_r  <= a_r;
      olast_r <= sts.i_last;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_sorted_value = oval_r;
  assign out_last_out     = olast_r;

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.cmp |-> (j_r < n_r) && (i_r < j_r))
    else $error("compare index out of range");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> (i_r < n_r))
    else $error("emit beyond set length");

  a_last_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && sts.i_last) |=> ctrl.load && (fill_r == '0))
    else $error("sequencer did not return to loading after final beat");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(ctrl.emit))
    else $error("result beat without emit step");

endmodule

[tb/tb.sv]
// Self-checking bench for exchange_sort_engine_unit: feeds sets of signed words and
// checks every sorted beat against a local sort of the set or a typed row's answer.
// Depends on esort_pkg and the engine RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_W    = esort_pkg::WORD_W;
  localparam int SET_MAX   = 16;
  localparam int N_ITEMS   = 410;
  localparam int N_DIR     = 24;
  localparam int CYC_LIMIT = 200000;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
    logic              typed;   // single-element row with a hand-written answer
    logic [WORD_W-1:0] want;
  } feed_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
  } beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [WORD_W-1:0] in_value = '0;
  logic              in_last_in = 1'b0;
  logic              out_strobe;
  logic [WORD_W-1:0] out_sorted_value;
  logic              out_last_out;

  feed_t                    feed_q[$];
  beat_t                    sorted_q[$];
  logic signed [WORD_W-1:0] open_set[$];
  int                       issue_idx = 0;
  int                       err_cnt = 0;
  int                       cyc_cnt = 0;

  exchange_sort_engine_unit #(.MAX_LEN(SET_MAX)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out)
  );

  always #6 clk = ~clk;

  function automatic logic [WORD_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      8: pick_word = 32'h8000_0000;
      9: pick_word = 32'h7FFF_FFFF;
      5, 6, 7: pick_word = $unsigned($urandom_range(0, 6) - 3);  // near zero, many ties
      default: pick_word = $urandom;
    endcase
  endfunction

  // Add one accepted word to the open set; close it on last or on a full store.
  task automatic absorb_word(input feed_t it);
    logic signed [WORD_W-1:0] tmp;
    int n;
    open_set.push_back(it.value);
    if (!it.last && open_set.size() < SET_MAX) return;
    n = open_set.size();
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (open_set[i] > open_set[j]) begin
          tmp         = open_set[i];
          open_set[i] = open_set[j];
          open_set[j] = tmp;
        end
      end
    end
    for (int k = 0; k < n; k++) sorted_q.push_back('{open_set[k], k == n - 1});
    open_set.delete();
    // single-element rows: take the hand-written answer
    if (it.typed) begin
      void'(sorted_q.pop_back());
      sorted_q.push_back('{it.want, 1'b1});
    end
  endtask

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cyc_cnt, sorted_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Feed driver: hold a word while busy, otherwise offer the next one or idle.
  always @(posedge clk) begin
    bit quiet;
    if (rst_n) begin
      if (start && !busy) begin
        absorb_word(feed_q[issue_idx]);
        issue_idx++;
      end
      if (!(start && busy)) begin
        quiet = issue_idx >= 160 && issue_idx < 260;
        if (issue_idx < feed_q.size() && (quiet || $urandom_range(0, 99) >= 35)) begin
          start      <= 1'b1;
          in_value   <= feed_q[issue_idx].value;
          in_last_in <= feed_q[issue_idx].last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobe must match the oldest outstanding beat.
  always @(posedge clk) begin
    beat_t exp_b;
    if (rst_n && out_strobe === 1'b1) begin
      if (sorted_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected beat: value %h last %b", out_sorted_value, out_last_out);
      end else begin
        exp_b = sorted_q.pop_front();
        if (out_sorted_value !== exp_b.value || out_last_out !== exp_b.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("beat mismatch: exp value %h last %b, got value %h last %b",
                     exp_b.value, exp_b.last, out_sorted_value, out_last_out);
        end
      end
    end else if (rst_n && out_strobe !== 1'b0) begin
      err_cnt++;
      if (err_cnt <= 10) $display("out_strobe unknown");
    end
  end

  initial begin
    feed_t dir_rows [N_DIR];
    feed_t row;
    int    n;

    dir_rows = '{
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
      // short set with a tie, a negative and the minimum
      '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
      // full store closes the set with last_in low
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'h4000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h0000_03E8, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFF9, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FC18, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0001, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0003, 1'b0, 1'b0, 32'h0}
    };
    for (int r = 0; r < N_DIR; r++) feed_q.push_back(dir_rows[r]);

    // random sets: mostly short, now and then a full store
    while (feed_q.size() < N_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? SET_MAX : $urandom_range(1, 8);
      for (int k = 0; k < n; k++) begin
        row.value = pick_word();
        row.typed = 1'b0;
        row.want  = '0;
        if (k != n - 1)     row.last = 1'b0;
        else if (n == SET_MAX) row.last = $urandom_range(0, 1);
        else                row.last = 1'b1;
        feed_q.push_back(row);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (issue_idx < feed_q.size() || sorted_q.size() != 0) @(posedge clk);
    // allow for a stray trailing beat
    repeat (50) @(posedge clk);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
